/* rtl/fpr_pkg.sv */
// Package for the framed packet receiver: parse phases, status codes,
// register indexes, reset values and the run request passed to the readout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  // Storage and run limits
  localparam int PAYLOAD_DEPTH_DEF = 16;
  localparam int RUN_MAX           = 16;

  // Configuration register reset values
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;

  // Configuration register indexes
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SUM_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_SUM   = 3'd4,
    PH_END   = 3'd5
  } phase_t;

  // Request from the parser to start a run of results
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [4:0] total;    // number of results, 1 to 16
    logic       use_mem;  // payload bytes come from the store
  } run_req_t;

endpackage

`default_nettype wire

/* rtl/fpr_payload_ram.sv */
// Payload store: single-write, single-read synchronous memory with a registered
// read port; read data holds while no read is enabled. Uses fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_payload_ram
  import fpr_pkg::*;
#(
  parameter int DEPTH = PAYLOAD_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fpr_parser.sv */
// Frame parser: marker registers, phase machine, checksum and length checks;
// writes payload bytes to the store and requests result runs. Uses fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_parser
  import fpr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_addr,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          byte_valid,
  input  wire logic [7:0]    rx_byte,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [7:0]    mem_wdata,
  output run_req_t           run_req,
  output logic      [7:0]    held_command,
  output logic      [7:0]    held_length
);

  localparam int LenLimit = (PAYLOAD_DEPTH < RUN_MAX) ? PAYLOAD_DEPTH : RUN_MAX;

  phase_t     phase, phase_next;
  logic [4:0] received_count, received_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_command_next, held_length_next;
  logic [7:0] start_marker, end_marker;
  logic [4:0] count_inc;

  assign count_inc = received_count + 5'd1;

  // Marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_MARKER: start_marker <= cfg_wdata;
        REG_END_MARKER:   end_marker   <= cfg_wdata;
        default:          start_marker <= start_marker;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (byte_valid) begin
      case (phase)
        PH_CMD:  phase_next = PH_LEN;
        PH_LEN: begin
          if (rx_byte > 8'(LenLimit)) begin
            phase_next = PH_START;
          end else if (rx_byte != 8'd0) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_SUM;
          end
        end
        PH_DATA: begin
          if ({3'd0, count_inc} >= held_length) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM:  phase_next = (rx_byte == running_sum) ? PH_END : PH_START;
        PH_END:  phase_next = PH_START;
        default: phase_next = (rx_byte == start_marker) ? PH_CMD : PH_START;
      endcase
    end
  end

  // Datapath, store writes and run requests
  always_comb begin
    received_count_next = received_count;
    running_sum_next    = running_sum;
    held_command_next   = held_command;
    held_length_next    = held_length;
    mem_we              = 1'b0;
    mem_waddr           = AW'(received_count);
    mem_wdata           = rx_byte;
    run_req             = '0;
    if (byte_valid) begin
      case (phase)
        PH_CMD: begin
          held_command_next = rx_byte;
          running_sum_next  = rx_byte;
        end
        PH_LEN: begin
          held_length_next    = rx_byte;
          running_sum_next    = running_sum + rx_byte;
          received_count_next = 5'd0;
          if (rx_byte > 8'(LenLimit)) begin
            run_req.valid  = 1'b1;
            run_req.status = ST_LEN_ERR;
            run_req.total  = 5'd1;
          end
        end
        PH_DATA: begin
          mem_we              = ({27'd0, received_count} < PAYLOAD_DEPTH);
          received_count_next = count_inc;
          running_sum_next    = running_sum + rx_byte;
        end
        PH_SUM: begin
          if (rx_byte != running_sum) begin
            run_req.valid  = 1'b1;
            run_req.status = ST_SUM_ERR;
            run_req.total  = 5'd1;
          end
        end
        PH_END: begin
          if (rx_byte == end_marker) begin
            run_req.valid  = 1'b1;
            run_req.status = ST_OK;
            if (held_length == 8'd0) begin
              run_req.total = 5'd1;
            end else begin
              run_req.total   = 5'(held_length);
              run_req.use_mem = 1'b1;
            end
          end
        end
        default: begin
          if (rx_byte == start_marker) begin
            running_sum_next = 8'd0;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      received_count <= 5'd0;
      running_sum    <= 8'd0;
      held_command   <= 8'd0;
      held_length    <= 8'd0;
    end else begin
      phase          <= phase_next;
      received_count <= received_count_next;
      running_sum    <= running_sum_next;
      held_command   <= held_command_next;
      held_length    <= held_length_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/fpr_readout.sv */
// Result readout: walks a run over the payload store, aligns the registered
// read data and drives the output item register. Uses fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_readout
  import fpr_pkg::*;
#(
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire run_req_t      run_req,
  input  wire logic [7:0]    held_command,
  input  wire logic [7:0]    held_length,
  output logic               busy,
  output logic               mem_re,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [7:0]    mem_rdata,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic      [1:0]    out_status,
  output logic      [7:0]    out_command,
  output logic      [7:0]    out_length,
  output logic      [3:0]    out_index,
  output logic      [7:0]    out_byte,
  output logic               out_last
);

  logic       adv;
  logic       issue_active;
  logic [4:0] issue_cnt, issue_total;
  logic [1:0] run_status;
  logic       run_mem;
  logic       issue_last;

  logic       s1_valid;
  logic [1:0] s1_status;
  logic [7:0] s1_command, s1_length;
  logic [3:0] s1_index;
  logic       s1_mem, s1_last;

  assign adv        = !out_valid || out_ready;
  assign issue_last = (issue_cnt + 5'd1) == issue_total;
  assign busy       = issue_active || s1_valid;
  assign mem_re     = adv && issue_active && run_mem;
  assign mem_raddr  = AW'(issue_cnt);

  // Issue counter: one entry of the run per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
      issue_cnt    <= 5'd0;
    end else if (run_req.valid) begin
      issue_active <= 1'b1;
      issue_cnt    <= 5'd0;
    end else if (adv && issue_active) begin
      issue_cnt <= issue_cnt + 5'd1;
      if (issue_last) begin
        issue_active <= 1'b0;
      end
    end
  end

  // Hold the run description
  always_ff @(posedge clk) begin
    if (run_req.valid) begin
      issue_total <= run_req.total;
      run_status  <= run_req.status;
      run_mem     <= run_req.use_mem;
    end
  end

  // Read stage, aligned with the store's read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue_active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue_active) begin
      s1_status  <= run_status;
      s1_command <= held_command;
      s1_length  <= held_length;
      s1_index   <= issue_cnt[3:0];
      s1_mem     <= run_mem;
      s1_last    <= issue_last;
    end
  end

  // Output item register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_status  <= s1_status;
      out_command <= s1_command;
      out_length  <= s1_length;
      out_index   <= s1_index;
      out_byte    <= s1_mem ? mem_rdata : 8'd0;
      out_last    <= s1_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/framed_packet_receiver.sv */
// Framed packet receiver top level: parser, payload store and readout.
// Depends on fpr_pkg, fpr_parser, fpr_payload_ram and fpr_readout.
//
// Usage: feed received bytes on s_tvalid/s_tready/s_tdata, one byte per item.
// The parser hunts for the start marker, then takes command, length, payload
// and checksum bytes and finally the end marker. Results leave on m_tvalid/
// m_tready/m_tdata/m_tlast: one item per payload byte for a good frame, or a
// single item for a zero-length frame, a checksum mismatch or an oversize
// length; a bad end marker drops the frame silently. m_tlast marks the final
// item of each run. Bytes are taken one per cycle while no run is in flight.
// A payload run of N results makes N store reads (one read port); input is held
// off (s_tready low) until the last entry of the run has left the read stage.
// The first result passes the issue counter, read stage and output item
// register. A stalled m_tready holds the output register and the store read
// in place. Markers are written through cfg_we/cfg_addr/cfg_wdata while idle;
// the user must keep to this, as the block does not enforce it. Synchronous
// reset returns the parser to hunting and restores the markers; the payload
// store is not cleared, as only bytes of the current frame are read.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver
  import fpr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] status, [9:2] command_code, [17:10] payload_length,
  // [21:18] payload_index, [29:22] payload_byte, [31:30] zero
  output logic      [31:0] m_tdata,
  output logic             m_tlast
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic          byte_valid;
  logic          busy;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  run_req_t      run_req;
  logic [7:0]    held_command, held_length;
  logic [1:0]    out_status;
  logic [7:0]    out_command, out_length, out_byte;
  logic [3:0]    out_index;

  // Take a byte only while no run is in flight
  assign s_tready   = !busy;
  assign byte_valid = s_tvalid && s_tready;

  fpr_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .AW           (AW)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .byte_valid  (byte_valid),
    .rx_byte     (s_tdata),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .run_req     (run_req),
    .held_command(held_command),
    .held_length (held_length)
  );

  fpr_payload_ram #(
    .DEPTH(PAYLOAD_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fpr_readout #(
    .AW(AW)
  ) u_readout (
    .clk         (clk),
    .rst         (rst),
    .run_req     (run_req),
    .held_command(held_command),
    .held_length (held_length),
    .busy        (busy),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_command (out_command),
    .out_length  (out_length),
    .out_index   (out_index),
    .out_byte    (out_byte),
    .out_last    (m_tlast)
  );

  // Pack the result fields, lowest first
  assign m_tdata = {2'b00, out_byte, out_index, out_length, out_command, out_status};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for framed_packet_receiver: directed frames from a table,
// then random frames under several marker settings and handshake idling patterns.
// Depends on fpr_pkg and the framed_packet_receiver RTL.
`timescale 1ns / 1ps

module tb_top;
  import fpr_pkg::*;

  localparam int LEN_LIMIT = (PAYLOAD_DEPTH_DEF < RUN_MAX) ? PAYLOAD_DEPTH_DEF : RUN_MAX;
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_DIRECTED = 26;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [3:0] payload_index;
    logic [7:0] payload_byte;
    logic       last;
  } rx_result_t;

  // One directed byte; a typed result replaces the predicted one
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    rx_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_START_MARKER;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] status, [9:2] command_code, [17:10] payload_length,
  // [21:18] payload_index, [29:22] payload_byte, [31:30] zero
  logic [31:0] m_tdata;
  logic        m_tlast;

  // Parser mirror: markers, phase and frame state
  logic [7:0]  mk_start = START_MARKER_RST;
  logic [7:0]  mk_end = END_MARKER_RST;
  phase_t      ph = PH_START;
  logic [4:0]  byte_count = '0;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  frame_cmd = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  frame_store [PAYLOAD_DEPTH_DEF];

  rx_result_t  expected_results [$];
  int          fail_count = 0;

  // Handshake idling controls
  int          gap_mode = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_tick = 0;
  int          hold_left = 0;

  dir_row_t    directed_rows [NUM_DIRECTED];
  logic [7:0]  start_set [NUM_PHASES];
  logic [7:0]  end_set [NUM_PHASES];

  framed_packet_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  // Advance the parser mirror by one byte and collect the results it yields
  task automatic mirror_step(input logic [7:0] b, inout rx_result_t made [$]);
    int run_len;
    case (ph)
      PH_CMD: begin
        frame_cmd = b;
        frame_sum = b;
        ph = PH_LEN;
      end
      PH_LEN: begin
        frame_len = b;
        frame_sum = frame_sum + b;
        byte_count = '0;
        if (b > LEN_LIMIT) begin
          made.push_back('{ST_LEN_ERR, frame_cmd, frame_len, 4'd0, 8'd0, 1'b1});
          ph = PH_START;
        end else begin
          ph = (b > 0) ? PH_DATA : PH_SUM;
        end
      end
      PH_DATA: begin
        if (byte_count < PAYLOAD_DEPTH_DEF) frame_store[byte_count[3:0]] = b;
        byte_count = byte_count + 5'd1;
        frame_sum = frame_sum + b;
        if (byte_count >= frame_len) ph = PH_SUM;
      end
      PH_SUM: begin
        if (b == frame_sum) begin
          ph = PH_END;
        end else begin
          made.push_back('{ST_SUM_ERR, frame_cmd, frame_len, 4'd0, 8'd0, 1'b1});
          ph = PH_START;
        end
      end
      PH_END: begin
        ph = PH_START;
        if (b == mk_end) begin
          if (frame_len == 0) begin
            made.push_back('{ST_OK, frame_cmd, frame_len, 4'd0, 8'd0, 1'b1});
          end else begin
            run_len = (frame_len > LEN_LIMIT) ? LEN_LIMIT : frame_len;
            for (int i = 0; i < run_len; i++) begin
              made.push_back('{ST_OK, frame_cmd, frame_len, 4'(i), frame_store[i],
                               (i + 1 == run_len)});
            end
          end
        end
      end
      default: begin
        // Hunt for the start marker; unused phase codes land here too
        ph = PH_START;
        if (b == mk_start) begin
          ph = PH_CMD;
          frame_sum = '0;
        end
      end
    endcase
  endtask

  // Offer one item, with gaps between bursts, and predict once it is taken
  task automatic send_item(input logic [7:0] b, input logic typed, input rx_result_t want);
    int gap;
    rx_result_t made [$];
    if (burst_left == 0) begin
      case (gap_mode)
        0: begin
          gap = 0;
          burst_left = 1000;
        end
        1: begin
          gap = $urandom_range(1, 3);
          burst_left = $urandom_range(1, 8);
        end
        default: begin
          gap = $urandom_range(0, 8);
          burst_left = $urandom_range(1, 4);
        end
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror_step(b, made);
    if (typed) expected_results.push_back(want);
    else foreach (made[i]) expected_results.push_back(made[i]);
  endtask

  task automatic write_marker(input logic idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == REG_START_MARKER) mk_start = v;
    else mk_end = v;
  endtask

  // Hold off until every expected result is out and the parser has settled
  task automatic settle;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random sequence: mostly good frames, the rest broken frames and noise
  task automatic send_random_sequence(output int counted);
    int kind;
    int noise_len;
    logic [7:0] cmd, len, sum, data;
    kind = $urandom_range(0, 9);
    counted = 0;
    if (kind == 9) begin
      noise_len = $urandom_range(1, 4);
      repeat (noise_len) send_item(8'($urandom), 1'b0, '0);
      counted = noise_len;
      return;
    end
    cmd = 8'($urandom);
    if (kind == 7)
      len = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(LEN_LIMIT + 1, 255));
    else if ($urandom_range(0, 7) == 0) len = 8'(LEN_LIMIT);
    else len = 8'($urandom_range(0, LEN_LIMIT));
    send_item(mk_start, 1'b0, '0);
    send_item(cmd, 1'b0, '0);
    send_item(len, 1'b0, '0);
    counted = 3;
    if (kind == 7) return;
    sum = cmd + len;
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom);
      sum = sum + data;
      send_item(data, 1'b0, '0);
    end
    counted = counted + len + 2;
    if (kind == 6) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(sum, 1'b0, '0);
    send_item((kind == 8) ? (mk_end ^ 8'($urandom_range(1, 255))) : mk_end, 1'b0, '0);
  endtask

  // Result side stall patterns
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ((stall_tick % 7) < 4);
      default: begin
        if (hold_left > 0) begin
          m_tready <= 1'b0;
          hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 19) == 0) begin
          m_tready <= 1'b0;
          hold_left <= $urandom_range(4, 12);
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    rx_result_t got_res;
    rx_result_t want_res;
    if (!rst && m_tvalid && m_tready) begin
      got_res = '{m_tdata[1:0], m_tdata[9:2], m_tdata[17:10], m_tdata[21:18],
                  m_tdata[29:22], m_tlast};
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("unexpected result item %h", m_tdata);
      end else begin
        want_res = expected_results.pop_front();
        // Keep the log bounded when the block is badly off
        if (got_res !== want_res || m_tdata[31:30] !== 2'b00) begin
          fail_count++;
          if (fail_count <= 100) begin
            if (got_res.status !== want_res.status)
              $error("status: expected %0d, got %0d", want_res.status, got_res.status);
            if (got_res.command_code !== want_res.command_code)
              $error("command_code: expected %0h, got %0h",
                     want_res.command_code, got_res.command_code);
            if (got_res.payload_length !== want_res.payload_length)
              $error("payload_length: expected %0h, got %0h",
                     want_res.payload_length, got_res.payload_length);
            if (got_res.payload_index !== want_res.payload_index)
              $error("payload_index: expected %0d, got %0d",
                     want_res.payload_index, got_res.payload_index);
            if (got_res.payload_byte !== want_res.payload_byte)
              $error("payload_byte: expected %0h, got %0h",
                     want_res.payload_byte, got_res.payload_byte);
            if (got_res.last !== want_res.last)
              $error("last: expected %0b, got %0b", want_res.last, got_res.last);
            if (m_tdata[31:30] !== 2'b00)
              $error("padding: expected 0, got %0b", m_tdata[31:30]);
          end
        end
      end
    end
  end

  initial begin
    int sent;
    int counted;

    // Frames under the reset markers: noise, zero length, oversize, bad checksum,
    // bad end marker, then a good two-byte frame
    directed_rows = '{
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h55, 1'b1, '{ST_OK, 8'h00, 8'h00, 4'd0, 8'h00, 1'b1}},
      '{8'hAA, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h11, 1'b1, '{ST_LEN_ERR, 8'hFF, 8'h11, 4'd0, 8'h00, 1'b1}},
      '{8'hAA, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b1, '{ST_SUM_ERR, 8'h12, 8'h01, 4'd0, 8'h00, 1'b1}},
      '{8'hAA, 1'b0, '0},
      '{8'h5A, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h5A, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h55, 1'b0, '0}
    };
    start_set = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, START_MARKER_RST};
    end_set = '{8'hFF, 8'h00, 8'($urandom), 8'h5A, END_MARKER_RST};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    gap_mode = 1;
    stall_mode <= 1;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random frames, one marker setting and idling pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_marker(REG_START_MARKER, start_set[p]);
      write_marker(REG_END_MARKER, end_set[p]);
      cfg_we <= 1'b0;
      gap_mode = p % 3;
      stall_mode <= (p + 1) % 4;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_sequence(counted);
        sent = sent + counted;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("framed_packet_receiver: match");
    end else begin
      $display("framed_packet_receiver: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("framed_packet_receiver: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/fpr_pkg.sv
rtl/fpr_payload_ram.sv
rtl/fpr_parser.sv
rtl/fpr_readout.sv
rtl/framed_packet_receiver.sv
tb/tb_top.sv
